@@ design/mscc_pkg.sv @@
// Shared types, constants and helpers for the marching-squares contour cell.
// No dependencies.
package mscc_pkg;

    localparam int VAL_W   = 16;
    localparam int SUM_W   = VAL_W + 1;
    localparam int IDX_W   = 10;
    localparam int PT_W    = 24;
    localparam int STEP_W  = 23;
    localparam int FRAC_W  = 12;
    localparam int R_W     = FRAC_W + 1;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES = FRAC_W / BITS_PER_STAGE;
    localparam int IPROD_W = IDX_W + STEP_W + 1;
    localparam int BASE_W  = IPROD_W + 1;
    localparam int WIDE_W  = BASE_W + 1;

    localparam logic [2:0] CFG_LEVEL_OFFSET = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_X     = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Y     = 3'd2;
    localparam logic [2:0] CFG_STEP_X       = 3'd3;
    localparam logic [2:0] CFG_STEP_Y       = 3'd4;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(4096);

    localparam logic [1:0] EDGE_LEFT   = 2'd0;
    localparam logic [1:0] EDGE_BOTTOM = 2'd1;
    localparam logic [1:0] EDGE_RIGHT  = 2'd2;
    localparam logic [1:0] EDGE_TOP    = 2'd3;

    typedef enum logic [1:0] {
        FM_ZERO,
        FM_FULL,
        FM_DIV
    } t_fmode;

    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][1:0] e;
    } t_seq;

    function automatic t_seq mscc_seq(input logic [3:0] code);
        t_seq s;
        s.n = 3'd2;
        s.e = '0;
        unique case (code)
            4'd8, 4'd7: begin
                s.e[0] = EDGE_LEFT;   s.e[1] = EDGE_BOTTOM;
            end
            4'd4, 4'd11: begin
                s.e[0] = EDGE_BOTTOM; s.e[1] = EDGE_RIGHT;
            end
            4'd1, 4'd14: begin
                s.e[0] = EDGE_RIGHT;  s.e[1] = EDGE_TOP;
            end
            4'd2, 4'd13: begin
                s.e[0] = EDGE_TOP;    s.e[1] = EDGE_LEFT;
            end
            4'd12, 4'd3: begin
                s.e[0] = EDGE_LEFT;   s.e[1] = EDGE_RIGHT;
            end
            4'd10, 4'd5: begin
                s.e[0] = EDGE_BOTTOM; s.e[1] = EDGE_TOP;
            end
            4'd9, 4'd6: begin
                s.n = 3'd4;
                s.e[0] = EDGE_LEFT;   s.e[1] = EDGE_BOTTOM;
                s.e[2] = EDGE_RIGHT;  s.e[3] = EDGE_TOP;
            end
            default: begin
                s.n = 3'd0;
            end
        endcase
        return s;
    endfunction

    function automatic logic [PT_W-1:0] mscc_sat(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(8388607);
        lo = -WIDE_W'(8388608);
        if (v > hi) begin
            return PT_W'(hi);
        end else if (v < lo) begin
            return PT_W'(lo);
        end
        return v[PT_W-1:0];
    endfunction

endpackage

@@ design/mscc_frac.sv @@
// Pipelined crossing-fraction unit: |a|*4096/|a-b| clamped to 0..4096.
// Two quotient bits per stage. Depends on mscc_pkg.
module mscc_frac (
    input  logic                                i_clk,
    input  logic                                i_adv,
    input  logic signed [mscc_pkg::SUM_W-1:0]   i_a,
    input  logic signed [mscc_pkg::SUM_W-1:0]   i_b,
    output logic        [mscc_pkg::R_W-1:0]     o_frac
);
    import mscc_pkg::*;

    logic signed [SUM_W:0] w_a;
    logic signed [SUM_W:0] w_d;
    logic [SUM_W-1:0]      w_na;
    logic [SUM_W-1:0]      w_nd;
    t_fmode                w_mode;

    logic [SUM_W-1:0]  r_rem  [0:DIV_STAGES];
    logic [SUM_W-1:0]  r_nd   [0:DIV_STAGES];
    logic [FRAC_W-1:0] r_q    [0:DIV_STAGES];
    t_fmode            r_mode [0:DIV_STAGES];

    always_comb begin
        w_a  = (SUM_W+1)'(i_a);
        w_d  = (SUM_W+1)'(i_a) - (SUM_W+1)'(i_b);
        w_na = w_a[SUM_W] ? SUM_W'(-w_a) : w_a[SUM_W-1:0];
        w_nd = w_d[SUM_W] ? SUM_W'(-w_d) : w_d[SUM_W-1:0];
        if (w_nd == '0) begin
            w_mode = FM_ZERO;
        end else if (w_na >= w_nd) begin
            w_mode = FM_FULL;
        end else begin
            w_mode = FM_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0]  <= w_na;
            r_nd[0]   <= w_nd;
            r_q[0]    <= '0;
            r_mode[0] <= w_mode;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [SUM_W-1:0]  n_rem;
        logic [FRAC_W-1:0] n_q;
        logic [SUM_W:0]    w_t;

        always_comb begin
            n_rem = r_rem[k];
            n_q   = r_q[k];
            w_t   = '0;
            for (int j = 0; j < BITS_PER_STAGE; j++) begin
                w_t = {n_rem, 1'b0};
                if (w_t >= {1'b0, r_nd[k]}) begin
                    n_rem = SUM_W'(w_t - {1'b0, r_nd[k]});
                    n_q   = {n_q[FRAC_W-2:0], 1'b1};
                end else begin
                    n_rem = w_t[SUM_W-1:0];
                    n_q   = {n_q[FRAC_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k+1]  <= n_rem;
                r_nd[k+1]   <= r_nd[k];
                r_q[k+1]    <= n_q;
                r_mode[k+1] <= r_mode[k];
            end
        end
    end

    always_comb begin
        unique case (r_mode[DIV_STAGES])
            FM_ZERO: o_frac = '0;
            FM_FULL: o_frac = R_W'(1) << FRAC_W;
            default: o_frac = {1'b0, r_q[DIV_STAGES]};
        endcase
    end

endmodule

@@ design/marching_squares_contour_cell_top.sv @@
// Accepted cell words pass corner sums, divider, scaling and point select
// into the point buffer. Throughput: one cell per cycle while o_stall is
// low; up to four points per cell leave on the single point output.
// One global advance moves every stage, so a stall holds all stages intact.
// Reset (synchronous, active low) clears valid bits and the point buffer;
// offset and origins return to 0, steps to 4096.
module marching_squares_contour_cell_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [mscc_pkg::IDX_W-1:0]  i_cell_col,
    input  logic signed [mscc_pkg::IDX_W-1:0]  i_cell_row,
    input  logic signed [mscc_pkg::VAL_W-1:0]  i_value_bl,
    input  logic signed [mscc_pkg::VAL_W-1:0]  i_value_br,
    input  logic signed [mscc_pkg::VAL_W-1:0]  i_value_tl,
    input  logic signed [mscc_pkg::VAL_W-1:0]  i_value_tr,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [mscc_pkg::PT_W-1:0]   o_point_x,
    output logic signed [mscc_pkg::PT_W-1:0]   o_point_y,
    output logic                               o_last_point,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [2:0]                         i_cfg_index,
    input  logic [mscc_pkg::PT_W-1:0]          i_cfg_data
);
    import mscc_pkg::*;

    localparam int META_N = DIV_STAGES + 1;

    logic signed [VAL_W-1:0]  r_level_offset;
    logic signed [PT_W-1:0]   r_origin_x;
    logic signed [PT_W-1:0]   r_origin_y;
    logic [STEP_W-1:0]        r_step_x;
    logic [STEP_W-1:0]        r_step_y;

    logic                      w_adv;
    logic                      w_can_load;
    logic                      r_v [0:META_N+2];

    logic signed [IDX_W-1:0]   r_col0;
    logic signed [IDX_W-1:0]   r_row0;
    logic signed [SUM_W-1:0]   r_s0 [0:3];

    logic [3:0]                r_code [1:META_N];
    logic signed [IPROD_W-1:0] r_cp   [1:META_N];
    logic signed [IPROD_W-1:0] r_rp   [1:META_N];

    logic [R_W-1:0]            w_frac [0:3];
    logic [PT_W-1:0]           r_sc   [0:3];
    logic signed [BASE_W-1:0]  r_bx;
    logic signed [BASE_W-1:0]  r_by;
    logic [3:0]                r_code8;

    logic signed [WIDE_W-1:0]  w_ex [0:3];
    logic signed [WIDE_W-1:0]  w_ey [0:3];
    t_seq                      w_seq;
    logic [PT_W-1:0]           r_px [0:3];
    logic [PT_W-1:0]           r_py [0:3];
    logic [2:0]                r_n9;

    logic [PT_W-1:0]           r_ox [0:3];
    logic [PT_W-1:0]           r_oy [0:3];
    logic [2:0]                r_left;
    logic [1:0]                r_idx;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_offset <= '0;
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_step_x       <= STEP_RESET;
            r_step_y       <= STEP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LEVEL_OFFSET: r_level_offset <= i_cfg_data[VAL_W-1:0];
                CFG_ORIGIN_X:     r_origin_x     <= i_cfg_data;
                CFG_ORIGIN_Y:     r_origin_y     <= i_cfg_data;
                CFG_STEP_X:       r_step_x       <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Y:       r_step_y       <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_can_load = (r_left == 3'd0) || (r_left == 3'd1 && !i_stall);
    assign w_adv      = !r_v[META_N+2] || w_can_load;
    assign o_stall    = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= META_N + 2; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= META_N + 2; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // corner sums and index products
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_col0  <= i_cell_col;
            r_row0  <= i_cell_row;
            r_s0[0] <= SUM_W'(i_value_bl) + SUM_W'(r_level_offset);
            r_s0[1] <= SUM_W'(i_value_br) + SUM_W'(r_level_offset);
            r_s0[2] <= SUM_W'(i_value_tl) + SUM_W'(r_level_offset);
            r_s0[3] <= SUM_W'(i_value_tr) + SUM_W'(r_level_offset);

            r_code[1] <= {!r_s0[0][SUM_W-1], !r_s0[1][SUM_W-1],
                          !r_s0[2][SUM_W-1], !r_s0[3][SUM_W-1]};
            r_cp[1]   <= IPROD_W'(r_col0) * $signed({{(IPROD_W-STEP_W){1'b0}}, r_step_x});
            r_rp[1]   <= IPROD_W'(r_row0) * $signed({{(IPROD_W-STEP_W){1'b0}}, r_step_y});
            for (int k = 2; k <= META_N; k++) begin
                r_code[k] <= r_code[k-1];
                r_cp[k]   <= r_cp[k-1];
                r_rp[k]   <= r_rp[k-1];
            end
        end
    end

    mscc_frac u_frac_left (
        .i_clk(i_clk), .i_adv(w_adv), .i_a(r_s0[0]), .i_b(r_s0[2]), .o_frac(w_frac[0])
    );
    mscc_frac u_frac_bottom (
        .i_clk(i_clk), .i_adv(w_adv), .i_a(r_s0[0]), .i_b(r_s0[1]), .o_frac(w_frac[1])
    );
    mscc_frac u_frac_right (
        .i_clk(i_clk), .i_adv(w_adv), .i_a(r_s0[1]), .i_b(r_s0[3]), .o_frac(w_frac[2])
    );
    mscc_frac u_frac_top (
        .i_clk(i_clk), .i_adv(w_adv), .i_a(r_s0[2]), .i_b(r_s0[3]), .o_frac(w_frac[3])
    );

    // scale fractions and form cell base
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sc[0] <= PT_W'(({{STEP_W{1'b0}}, w_frac[0]} * {{R_W{1'b0}}, r_step_y}) >> FRAC_W);
            r_sc[1] <= PT_W'(({{STEP_W{1'b0}}, w_frac[1]} * {{R_W{1'b0}}, r_step_x}) >> FRAC_W);
            r_sc[2] <= PT_W'(({{STEP_W{1'b0}}, w_frac[2]} * {{R_W{1'b0}}, r_step_y}) >> FRAC_W);
            r_sc[3] <= PT_W'(({{STEP_W{1'b0}}, w_frac[3]} * {{R_W{1'b0}}, r_step_x}) >> FRAC_W);
            r_bx    <= BASE_W'(r_origin_x) + BASE_W'(r_cp[META_N]);
            r_by    <= BASE_W'(r_origin_y) + BASE_W'(r_rp[META_N]);
            r_code8 <= r_code[META_N];
        end
    end

    always_comb begin
        w_ex[0] = WIDE_W'(r_bx);
        w_ey[0] = WIDE_W'(r_by) + WIDE_W'({1'b0, r_sc[0]});
        w_ex[1] = WIDE_W'(r_bx) + WIDE_W'({1'b0, r_sc[1]});
        w_ey[1] = WIDE_W'(r_by);
        w_ex[2] = WIDE_W'(r_bx) + WIDE_W'({1'b0, r_step_x});
        w_ey[2] = WIDE_W'(r_by) + WIDE_W'({1'b0, r_sc[2]});
        w_ex[3] = WIDE_W'(r_bx) + WIDE_W'({1'b0, r_sc[3]});
        w_ey[3] = WIDE_W'(r_by) + WIDE_W'({1'b0, r_step_y});
        w_seq   = mscc_seq(r_code8);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 4; k++) begin
                r_px[k] <= mscc_sat(w_ex[w_seq.e[k]]);
                r_py[k] <= mscc_sat(w_ey[w_seq.e[k]]);
            end
            r_n9 <= w_seq.n;
        end
    end

    // point buffer: drain one word per cycle while i_stall is low
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else if (r_v[META_N+2] && w_adv) begin
            r_left <= r_n9;
            r_idx  <= '0;
        end else if (o_valid && !i_stall) begin
            r_left <= r_left - 3'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v[META_N+2] && w_adv) begin
            r_ox <= r_px;
            r_oy <= r_py;
        end
    end

    assign o_valid      = (r_left != 3'd0);
    assign o_point_x    = r_ox[r_idx];
    assign o_point_y    = r_oy[r_idx];
    assign o_last_point = (r_left == 3'd1);

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 3'd4)
        else $error("point count out of range");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[META_N+2] && w_adv) |=> (r_left == 3'd0 || r_left == 3'd2 || r_left == 3'd4))
        else $error("bad point count loaded");

    a_last_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_point && !r_v[META_N+2]) |=> !o_valid)
        else $error("buffer not empty after last point");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (r_left == $past(r_left) && r_idx == $past(r_idx)))
        else $error("buffer moved under stall");

endmodule

@@ tb/marching_squares_contour_cell_checker.sv @@
// Checker for the marching-squares contour cell: watches the cell, point and register
// channels, predicts the contour points of each accepted cell and compares them.
// Depends on mscc_pkg.
module marching_squares_contour_cell_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_stall_in,
    input  logic signed [mscc_pkg::IDX_W-1:0] i_cell_col,
    input  logic signed [mscc_pkg::IDX_W-1:0] i_cell_row,
    input  logic signed [mscc_pkg::VAL_W-1:0] i_value_bl,
    input  logic signed [mscc_pkg::VAL_W-1:0] i_value_br,
    input  logic signed [mscc_pkg::VAL_W-1:0] i_value_tl,
    input  logic signed [mscc_pkg::VAL_W-1:0] i_value_tr,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [mscc_pkg::PT_W-1:0]  i_point_x,
    input  logic signed [mscc_pkg::PT_W-1:0]  i_point_y,
    input  logic                              i_last_point,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [2:0]                        i_cfg_index,
    input  logic [mscc_pkg::PT_W-1:0]         i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_points_seen
);
    import mscc_pkg::*;

    typedef struct {
        logic [PT_W-1:0] x;
        logic [PT_W-1:0] y;
        logic            last;
    } t_point;

    t_point            point_queue[$];
    logic signed [63:0] offset_q, org_x, org_y;
    logic [63:0]       stp_x, stp_y;

    function automatic logic [63:0] cross_frac(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
        logic signed [63:0] d;
        logic [63:0] na, nd, r;
        d  = a - b;
        na = (a < 0) ? -a : a;
        nd = (d < 0) ? -d : d;
        if (nd == 0) return 0;
        r = (na * 4096) / nd;
        return (r > 4096) ? 64'd4096 : r;
    endfunction

    function automatic logic [PT_W-1:0] clip24(input logic signed [63:0] v);
        if (v > 64'sd8388607) return 24'h7FFFFF;
        if (v < -64'sd8388608) return 24'h800000;
        return v[PT_W-1:0];
    endfunction

    task automatic predict_points();
        logic signed [63:0] bl, br, tl, tr, bx, by;
        logic signed [63:0] ex[4], ey[4];
        logic [3:0] code;
        int order[4];
        int n;
        t_point p;
        bl = 64'(i_value_bl) + offset_q;
        br = 64'(i_value_br) + offset_q;
        tl = 64'(i_value_tl) + offset_q;
        tr = 64'(i_value_tr) + offset_q;
        bx = org_x + 64'(i_cell_col) * $signed(stp_x);
        by = org_y + 64'(i_cell_row) * $signed(stp_y);
        code = {bl >= 0, br >= 0, tl >= 0, tr >= 0};
        ex[EDGE_LEFT]   = bx;
        ey[EDGE_LEFT]   = by + $signed((cross_frac(bl, tl) * stp_y) >> 12);
        ex[EDGE_BOTTOM] = bx + $signed((cross_frac(bl, br) * stp_x) >> 12);
        ey[EDGE_BOTTOM] = by;
        ex[EDGE_RIGHT]  = bx + $signed(stp_x);
        ey[EDGE_RIGHT]  = by + $signed((cross_frac(br, tr) * stp_y) >> 12);
        ex[EDGE_TOP]    = bx + $signed((cross_frac(tl, tr) * stp_x) >> 12);
        ey[EDGE_TOP]    = by + $signed(stp_y);
        n = 2;
        case (code)
            4'd8, 4'd7:  begin order[0] = EDGE_LEFT;   order[1] = EDGE_BOTTOM; end
            4'd4, 4'd11: begin order[0] = EDGE_BOTTOM; order[1] = EDGE_RIGHT; end
            4'd1, 4'd14: begin order[0] = EDGE_RIGHT;  order[1] = EDGE_TOP; end
            4'd2, 4'd13: begin order[0] = EDGE_TOP;    order[1] = EDGE_LEFT; end
            4'd12, 4'd3: begin order[0] = EDGE_LEFT;   order[1] = EDGE_RIGHT; end
            4'd10, 4'd5: begin order[0] = EDGE_BOTTOM; order[1] = EDGE_TOP; end
            4'd9, 4'd6: begin
                n = 4;
                order[0] = EDGE_LEFT;  order[1] = EDGE_BOTTOM;
                order[2] = EDGE_RIGHT; order[3] = EDGE_TOP;
            end
            default: n = 0;
        endcase
        for (int k = 0; k < n; k++) begin
            p.x = clip24(ex[order[k]]);
            p.y = clip24(ey[order[k]]);
            p.last = (k == n - 1);
            point_queue.push_back(p);
        end
    endtask

    always @(posedge i_clk) begin
        t_point exp_pt;
        if (!i_rst_n) begin
            offset_q <= 0;
            org_x <= 0;
            org_y <= 0;
            stp_x <= 4096;
            stp_y <= 4096;
            point_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LEVEL_OFFSET: offset_q <= 64'($signed(i_cfg_data[15:0]));
                    CFG_ORIGIN_X:     org_x <= 64'($signed(i_cfg_data));
                    CFG_ORIGIN_Y:     org_y <= 64'($signed(i_cfg_data));
                    CFG_STEP_X:       stp_x <= 64'(i_cfg_data[STEP_W-1:0]);
                    CFG_STEP_Y:       stp_y <= 64'(i_cfg_data[STEP_W-1:0]);
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                o_points_seen <= o_points_seen + 1;
                if (point_queue.size() == 0) begin
                    $error("unexpected point word x=%0d y=%0d", i_point_x, i_point_y);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_pt = point_queue.pop_front();
                    if (exp_pt.x !== i_point_x || exp_pt.y !== i_point_y
                            || exp_pt.last !== i_last_point) begin
                        if (exp_pt.x !== i_point_x)
                            $error("point_x expected %0d actual %0d",
                                   $signed(exp_pt.x), i_point_x);
                        if (exp_pt.y !== i_point_y)
                            $error("point_y expected %0d actual %0d",
                                   $signed(exp_pt.y), i_point_y);
                        if (exp_pt.last !== i_last_point)
                            $error("last_point expected %0d actual %0d",
                                   exp_pt.last, i_last_point);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_valid && !i_stall_in) predict_points();
        end
        o_pending <= point_queue.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_points_seen = 0;
    end
endmodule

@@ tb/marching_squares_contour_cell_top_test.sv @@
// Testbench top for the marching-squares contour cell: drives cell words, register
// writes and output stalls over several idling phases and gives the verdict.
// Depends on mscc_pkg, marching_squares_contour_cell_top and its checker.
module marching_squares_contour_cell_top_test;
    import mscc_pkg::*;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall, last_pt;
    logic signed [IDX_W-1:0] col, row;
    logic signed [VAL_W-1:0] v_bl, v_br, v_tl, v_tr;
    logic signed [PT_W-1:0]  pt_x, pt_y;
    logic cfg_valid, cfg_ready;
    logic [2:0] cfg_index;
    logic [PT_W-1:0] cfg_data;
    int fail_count, pending, points_seen, cycle_count, cells_sent;
    int send_idle_pct, recv_stall_pct;

    marching_squares_contour_cell_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_cell_col(col), .i_cell_row(row), .i_value_bl(v_bl), .i_value_br(v_br),
        .i_value_tl(v_tl), .i_value_tr(v_tr), .o_valid(out_valid),
        .i_stall(out_stall), .o_point_x(pt_x), .o_point_y(pt_y),
        .o_last_point(last_pt), .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    marching_squares_contour_cell_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_cell_col(col), .i_cell_row(row), .i_value_bl(v_bl), .i_value_br(v_br),
        .i_value_tl(v_tl), .i_value_tr(v_tr), .i_out_valid(out_valid),
        .i_out_stall(out_stall), .i_point_x(pt_x), .i_point_y(pt_y),
        .i_last_point(last_pt), .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_points_seen(points_seen)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);

    task automatic write_reg(input logic [2:0] idx, input logic [PT_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
    endtask

    // hold the word until accepted; valid stays high across back-to-back words
    task automatic send_cell(input logic signed [IDX_W-1:0] c, input logic signed [IDX_W-1:0] r,
                             input logic signed [VAL_W-1:0] bl, input logic signed [VAL_W-1:0] br,
                             input logic signed [VAL_W-1:0] tl,
                             input logic signed [VAL_W-1:0] tr);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        col <= c; row <= r; v_bl <= bl; v_br <= br; v_tl <= tl; v_tr <= tr;
        do @(posedge clk); while (in_stall);
        cells_sent++;
    endtask

    task automatic idle_sender();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    function automatic logic signed [VAL_W-1:0] corner();
        case ($urandom_range(3))
            0: return VAL_W'($urandom);
            1: return VAL_W'($signed($urandom_range(512)) - 256);
            2: return ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
            default: return VAL_W'($signed($urandom_range(16384)) - 8192);
        endcase
    endfunction

    task automatic random_cells(input int count);
        logic signed [IDX_W-1:0] c, r;
        for (int i = 0; i < count; i++) begin
            c = ($urandom_range(9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(259) - 2);
            r = ($urandom_range(9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(259) - 2);
            send_cell(c, r, corner(), corner(), corner(), corner());
        end
        idle_sender();
    endtask

    initial begin
        cycle_count = 0;
        cells_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LEVEL_OFFSET;
        cfg_data = '0;
        col = '0; row = '0; v_bl = '0; v_br = '0; v_tl = '0; v_tr = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every code, saddles, zero sums, extremes and wrapped indices
        for (int code = 0; code < 16; code++)
            send_cell(IDX_W'(code), IDX_W'(code - 2),
                      code[3] ? 16'sd300 : -16'sd500, code[2] ? 16'sd0 : -16'sd1,
                      code[1] ? 16'sd4095 : -16'sd4096, code[0] ? 16'sd1 : -16'sd2000);
        send_cell(-10'sd2, 10'sd257, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
        send_cell(10'sh1FF, 10'sh200, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_cell(10'sh3FF, 10'sd0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF);
        idle_sender();
        drain();

        // wide origins and steps push points into saturation
        write_reg(CFG_LEVEL_OFFSET, 24'h007FFF);
        write_reg(CFG_ORIGIN_X, 24'h7FFFFF);
        write_reg(CFG_ORIGIN_Y, 24'h800000);
        write_reg(CFG_STEP_X, 24'h7FFFFF);
        write_reg(CFG_STEP_Y, 24'h000000);
        send_cell(10'sh1FF, -10'sh200, 16'sh8000, 16'sh7FFF, 16'sh8001, 16'sh0);
        send_cell(-10'sh200, 10'sh1FF, 16'sh8000, 16'sh0, 16'sh7FFF, 16'sh8000);
        idle_sender();
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 30 : 65) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 30 : 65) : 0;
            case (ph)
                0: write_reg(CFG_LEVEL_OFFSET, 24'h008000);
                1: write_reg(CFG_LEVEL_OFFSET, 24'(VAL_W'($urandom)));
                default: write_reg(CFG_LEVEL_OFFSET,
                                   24'(VAL_W'($signed($urandom_range(2048)) - 1024)));
            endcase
            write_reg(CFG_ORIGIN_X, (ph == 0) ? 24'h000000 : 24'($urandom));
            write_reg(CFG_ORIGIN_Y, (ph == 0) ? 24'hFFF000 : 24'($urandom_range(65535)));
            write_reg(CFG_STEP_X, (ph == 0) ? 24'd4096 : 24'($urandom_range(8388607)));
            write_reg(CFG_STEP_Y, (ph == 1) ? 24'd1 : 24'($urandom_range(65535)));
            random_cells(36);
            drain();
            random_cells(36);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        $display("Sent %0d cells over six register settings and four idling phases;",
                 cells_sent);
        $display("checked %0d contour points.", points_seen);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

@@ marching_squares_contour_cell_top.f @@
design/mscc_pkg.sv
design/mscc_frac.sv
design/marching_squares_contour_cell_top.sv
tb/marching_squares_contour_cell_checker.sv
tb/marching_squares_contour_cell_top_test.sv
